>>> hdl/mct_pkg.sv
package mct_pkg;

    localparam int COORD_W    = 10;
    localparam int MASK_W     = 8;
    localparam int MARGIN_W   = 8;
    localparam int AREA_W     = 21;
    localparam int SUM_W      = 30;
    localparam int THR_W      = AREA_W + 2;
    localparam int CMP_W      = 13;
    localparam int DIV_CNT_W  = 5;
    localparam int CFG_IDX_W  = 3;

    localparam logic [MASK_W-1:0]  MASK_ON      = 8'd255;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 8'd5;
    localparam logic [COORD_W-1:0] COORD_MAX    = 10'd1023;

    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int MAX_HEIGHT_DEF   = 1024;
    localparam int GROW_DIVISOR_DEF = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y  = 3'd3;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [MASK_W-1:0]  mask_value;
        logic               frame_end;
    } t_pix;

    typedef struct packed {
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic               object_active;
        logic [AREA_W-1:0]  object_pixels;
        logic               object_found;
    } t_res;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] idx;
        logic [AREA_W-1:0]    wdata;
    } t_cfg;

    // Which division the shared divider performs.
    typedef enum logic {
        DSEL_SX,
        DSEL_SY
    } t_dsel;

    typedef struct packed {
        logic  pix_ready;
        logic  div_start;
        t_dsel div_sel;
        logic  commit;
    } t_cmd;

    typedef struct packed {
        logic frame_done;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

>>> hdl/mct_stream_if.sv
interface mct_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/mct_ctrl.sv
module mct_ctrl
    import mct_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_ACC,
        ST_START,
        ST_RUN,
        ST_HOLD
    } t_state;

    t_state r_state;
    t_dsel  r_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACC;
            r_sel   <= DSEL_SX;
        end else begin
            case (r_state)
                ST_ACC: begin
                    if (i_sts.frame_done) begin
                        r_state <= ST_START;
                        r_sel   <= DSEL_SX;
                    end
                end
                ST_START: begin
                    r_state <= ST_RUN;
                end
                ST_RUN: begin
                    if (i_sts.div_done) begin
                        if (r_sel == DSEL_SY) begin
                            r_state <= ST_HOLD;
                        end else begin
                            r_sel   <= DSEL_SY;
                            r_state <= ST_START;
                        end
                    end
                end
                ST_HOLD: begin
                    if (i_sts.out_free) begin
                        r_state <= ST_ACC;
                    end
                end
                default: begin
                    r_state <= ST_ACC;
                end
            endcase
        end
    end

    assign o_cmd.pix_ready = (r_state == ST_ACC);
    assign o_cmd.div_start = (r_state == ST_START);
    assign o_cmd.div_sel   = r_sel;
    assign o_cmd.commit    = (r_state == ST_HOLD) && i_sts.out_free;

endmodule

>>> hdl/mct_datapath.sv
module mct_datapath
    import mct_pkg::*;
#(
    parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT   = MAX_HEIGHT_DEF,
    parameter int GROW_DIVISOR = GROW_DIVISOR_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    output t_sts          o_sts,
    mct_stream_if.sink    i_pix,
    mct_stream_if.source  o_res,
    mct_stream_if.sink    i_cfg
);

    // Reciprocals for the threshold divisions; with a shift of the area width plus
    // ceil(log2(divisor)) the truncated quotient is exact for every area value.
    localparam int RCP_W  = AREA_W + 1;
    localparam int PROD_W = AREA_W + RCP_W;
    localparam int HI_SH  = AREA_W + $clog2(GROW_DIVISOR);
    localparam int LO_SH  = AREA_W + $clog2(2 * GROW_DIVISOR);
    localparam logic [RCP_W-1:0] HI_RCP =
        RCP_W'(((64'd1 << HI_SH) + 64'(GROW_DIVISOR) - 64'd1) / 64'(GROW_DIVISOR));
    localparam logic [RCP_W-1:0] LO_RCP =
        RCP_W'(((64'd1 << LO_SH) + 64'(2 * GROW_DIVISOR) - 64'd1) / 64'(2 * GROW_DIVISOR));

    function automatic logic [COORD_W-1:0] f_deadband(
        input logic [COORD_W-1:0]  t,
        input logic [COORD_W-1:0]  c,
        input logic [MARGIN_W-1:0] m
    );
        logic [COORD_W:0] t_hi;
        logic [COORD_W:0] c_hi;
        t_hi = {1'b0, t} + {3'b0, m};
        c_hi = {1'b0, c} + {3'b0, m};
        if (({1'b0, c} > t_hi) || (c_hi < {1'b0, t})) begin
            return c;
        end
        return t;
    endfunction

    // Configuration and tracking state
    logic [MARGIN_W-1:0] r_margin;
    logic [AREA_W-1:0]   r_area;
    logic [COORD_W-1:0]  r_trk_x;
    logic [COORD_W-1:0]  r_trk_y;
    logic                r_active;

    // Accumulators
    logic [SUM_W-1:0]    r_sum_x;
    logic [SUM_W-1:0]    r_sum_y;
    logic [AREA_W-1:0]   r_hit;

    // Shared divider
    logic                r_div_busy;
    logic                r_div_done;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    t_dsel               r_div_sel;
    logic [SUM_W-1:0]    r_dvd;
    logic [AREA_W-1:0]   r_dvs;
    logic [AREA_W-1:0]   r_rem;
    logic [SUM_W-1:0]    r_quo;

    // Division results
    logic [COORD_W-1:0]  r_cen_x;
    logic [COORD_W-1:0]  r_cen_y;
    logic [AREA_W-1:0]   r_q_hi;
    logic [AREA_W-1:0]   r_q_lo;

    // Output register
    logic                r_out_valid;
    t_res                r_res;

    logic                pix_fire;
    logic                pix_hit;
    logic [SUM_W:0]      n_sum_x;
    logic [SUM_W:0]      n_sum_y;
    logic [AREA_W:0]     rem_sh;
    logic [AREA_W:0]     rem_diff;
    logic                rem_ge;
    logic [SUM_W-1:0]    dvd_sel;
    logic [AREA_W-1:0]   dvs_sel;
    logic [COORD_W-1:0]  quo_clamp;
    logic [PROD_W-1:0]   prod_hi;
    logic [PROD_W-1:0]   prod_lo;
    logic [THR_W-1:0]    thr_hi;
    logic [THR_W-1:0]    thr_lo;
    logic [THR_W-1:0]    cnt_ext;
    logic                found;
    logic                n_active;
    logic                out_free;

    assign pix_fire = i_pix.valid && i_cmd.pix_ready;
    assign pix_hit  = (i_pix.data.mask_value == MASK_ON)
                   && ({3'b0, i_pix.data.pixel_x} < CMP_W'(MAX_WIDTH))
                   && ({3'b0, i_pix.data.pixel_y} < CMP_W'(MAX_HEIGHT));
    assign n_sum_x  = {1'b0, r_sum_x} + (SUM_W+1)'(i_pix.data.pixel_x);
    assign n_sum_y  = {1'b0, r_sum_y} + (SUM_W+1)'(i_pix.data.pixel_y);

    assign i_pix.ready = i_cmd.pix_ready;
    assign i_cfg.ready = 1'b1;

    // One restoring step per cycle, most significant dividend bit first.
    assign rem_sh   = {r_rem, r_dvd[SUM_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, r_dvs};
    assign rem_diff = rem_sh - {1'b0, r_dvs};

    always_comb begin
        case (i_cmd.div_sel)
            DSEL_SX: begin
                dvd_sel = r_sum_x;
                dvs_sel = r_hit;
            end
            DSEL_SY: begin
                dvd_sel = r_sum_y;
                dvs_sel = r_hit;
            end
            default: begin
                dvd_sel = r_sum_x;
                dvs_sel = r_hit;
            end
        endcase
    end

    assign quo_clamp = (r_quo > SUM_W'(COORD_MAX)) ? COORD_MAX : r_quo[COORD_W-1:0];

    assign prod_hi = PROD_W'(r_area) * PROD_W'(HI_RCP);
    assign prod_lo = PROD_W'(r_area) * PROD_W'(LO_RCP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_div_done <= 1'b0;
            r_div_cnt  <= '0;
        end else begin
            r_div_done <= 1'b0;
            if (i_cmd.div_start) begin
                r_div_busy <= 1'b1;
                r_div_cnt  <= '0;
            end else if (r_div_busy) begin
                if (r_div_cnt == DIV_CNT_W'(SUM_W - 1)) begin
                    r_div_busy <= 1'b0;
                    r_div_done <= 1'b1;
                end else begin
                    r_div_cnt <= r_div_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // User changes area register only while idle (not enforced), so these settle before frame end.
        r_q_hi <= AREA_W'(prod_hi >> HI_SH);
        r_q_lo <= AREA_W'(prod_lo >> LO_SH);
        if (i_cmd.div_start) begin
            r_div_sel <= i_cmd.div_sel;
            r_dvd     <= dvd_sel;
            r_dvs     <= dvs_sel;
            r_rem     <= '0;
            r_quo     <= '0;
        end else if (r_div_busy) begin
            r_dvd <= {r_dvd[SUM_W-2:0], 1'b0};
            r_rem <= rem_ge ? rem_diff[AREA_W-1:0] : rem_sh[AREA_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], rem_ge};
        end
        if (r_div_done) begin
            case (r_div_sel)
                DSEL_SX: r_cen_x <= quo_clamp;
                DSEL_SY: r_cen_y <= quo_clamp;
                default: r_cen_x <= quo_clamp;
            endcase
        end
    end

    // Frame-end decision
    assign found   = (r_hit != '0);
    assign cnt_ext = THR_W'(r_hit);
    assign thr_hi  = THR_W'(r_area) + THR_W'(r_q_hi);
    assign thr_lo  = THR_W'(r_area) + THR_W'(r_q_lo);

    always_comb begin
        n_active = r_active;
        if (cnt_ext > thr_hi) begin
            n_active = 1'b1;
        end else if (cnt_ext < thr_lo) begin
            n_active = 1'b0;
        end
    end

    assign out_free = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin    <= MARGIN_RESET;
            r_area      <= '0;
            r_trk_x     <= '0;
            r_trk_y     <= '0;
            r_active    <= 1'b0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_hit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.data.idx)
                    CFG_MARGIN:  r_margin <= i_cfg.data.wdata[MARGIN_W-1:0];
                    CFG_AREA:    r_area   <= i_cfg.data.wdata;
                    CFG_START_X: r_trk_x  <= i_cfg.data.wdata[COORD_W-1:0];
                    CFG_START_Y: r_trk_y  <= i_cfg.data.wdata[COORD_W-1:0];
                    default: ;
                endcase
            end

            if (pix_fire && pix_hit) begin
                r_sum_x <= n_sum_x[SUM_W] ? '1 : n_sum_x[SUM_W-1:0];
                r_sum_y <= n_sum_y[SUM_W] ? '1 : n_sum_y[SUM_W-1:0];
                if (r_hit != '1) begin
                    r_hit <= r_hit + 1'b1;
                end
            end

            if (i_cmd.commit) begin
                if (found) begin
                    r_trk_x <= f_deadband(r_trk_x, r_cen_x, r_margin);
                    r_trk_y <= f_deadband(r_trk_y, r_cen_y, r_margin);
                end
                r_active    <= n_active;
                r_sum_x     <= '0;
                r_sum_y     <= '0;
                r_hit       <= '0;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_res.center_x      <= found ? f_deadband(r_trk_x, r_cen_x, r_margin) : r_trk_x;
            r_res.center_y      <= found ? f_deadband(r_trk_y, r_cen_y, r_margin) : r_trk_y;
            r_res.object_active <= n_active;
            r_res.object_pixels <= r_hit;
            r_res.object_found  <= found;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_res;

    assign o_sts.frame_done = pix_fire && i_pix.data.frame_end;
    assign o_sts.div_done   = r_div_done;
    assign o_sts.out_free   = out_free;

endmodule

>>> hdl/mask_centroid_tracker_unit.sv
// Binary-mask centroid tracker. Mask pixels are taken one per clock on i_pix while the block
// accumulates; a pixel whose mask byte is 255 and that lies inside MAX_WIDTH x MAX_HEIGHT adds
// its column and row to saturating sums and bumps the object count. The frame-end pixel is
// counted too, then the block stops taking pixels while a single radix-2 divider performs
// two 30-step divisions in turn (column sum, then row sum) and until the result is loaded;
// loading waits while an earlier result still sits in the output register. The
// hysteresis thresholds reference_area + reference_area/GROW_DIVISOR and reference_area +
// reference_area/(2*GROW_DIVISOR) use quotients from a constant reciprocal multiply on the
// area register. One result per frame is placed in the output register and the accumulators
// clear. Pixels of the next frame are accepted while that result waits to be taken. Each
// tracked coordinate follows the truncated centroid only when it lies more than margin pixels
// away; an empty frame keeps the center. Writing start_center_x or start_center_y moves the
// tracked center at once. Configuration is to be written by the user only while the block
// is idle; the block itself does not enforce this.
module mask_centroid_tracker_unit
    import mct_pkg::*;
#(
    parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT   = MAX_HEIGHT_DEF,
    parameter int GROW_DIVISOR = GROW_DIVISOR_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mct_stream_if.sink   i_pix,
    mct_stream_if.source o_res,
    mct_stream_if.sink   i_cfg
);

    t_cmd cmd;
    t_sts sts;

    mct_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    mct_datapath #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .GROW_DIVISOR (GROW_DIVISOR)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_pix   (i_pix),
        .o_res   (o_res),
        .i_cfg   (i_cfg)
    );

endmodule

>>> tb/sv/tb_mask_centroid_tracker_unit.sv
`timescale 1ns / 1ps

module tb_mask_centroid_tracker_unit;
    import mct_pkg::*;

    localparam int CFG_NUM_REGS   = 4;
    localparam int SETTLE_CYCLES  = 200;
    localparam int HOLD_CYCLES    = 1500;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_PIXELS   = 250;
    localparam int HOLD_PHASE     = 2;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam logic [AREA_W-1:0] AREA_ALL = '1;
    localparam logic [AREA_W-1:0] AREA_TOP = 21'd1048576;

    // Tracks the accumulators, tracked center and hysteresis flag, and holds the
    // frame results the block still owes.
    class centroid_scoreboard;
        logic [MARGIN_W-1:0] margin;
        logic [AREA_W-1:0]   ref_area;
        logic [COORD_W-1:0]  start_x;
        logic [COORD_W-1:0]  start_y;
        logic [SUM_W-1:0]    col_sum;
        logic [SUM_W-1:0]    row_sum;
        logic [AREA_W-1:0]   hits;
        logic [COORD_W-1:0]  track_x;
        logic [COORD_W-1:0]  track_y;
        logic                active;
        t_res                expected_frames[$];
        int                  errors;
        int                  frames;
        int                  empty_frames;
        int                  active_frames;
        int                  checked;

        function new();
            margin   = MARGIN_RESET;
            ref_area = '0;
            start_x  = '0;
            start_y  = '0;
            col_sum  = '0;
            row_sum  = '0;
            hits     = '0;
            track_x  = '0;
            track_y  = '0;
            active   = 1'b0;
            errors   = 0;
            frames   = 0;
            empty_frames  = 0;
            active_frames = 0;
            checked  = 0;
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction

        function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [AREA_W-1:0] value);
            case (idx)
                CFG_MARGIN: begin
                    margin = value[MARGIN_W-1:0];
                end
                CFG_AREA: begin
                    ref_area = value;
                end
                CFG_START_X: begin
                    start_x = value[COORD_W-1:0];
                    track_x = start_x;
                end
                CFG_START_Y: begin
                    start_y = value[COORD_W-1:0];
                    track_y = start_y;
                end
                default: begin
                end
            endcase
        endfunction

        // The tracked coordinate jumps to the centroid only outside the deadband.
        function logic [COORD_W-1:0] follow_centroid(logic [COORD_W-1:0] held,
                                                     longint sum, longint n);
            longint q;
            int     c;
            int     t;
            int     m;
            q = sum / n;
            if (q > COORD_MAX) q = COORD_MAX;
            c = int'(q);
            t = held;
            m = margin;
            if (c > t + m || c < t - m) return c[COORD_W-1:0];
            return held;
        endfunction

        function void note_pixel(t_pix p);
            longint sx;
            longint sy;
            longint area;
            longint lim_hi;
            longint lim_lo;
            longint n;
            t_res   r;
            if (p.mask_value == MASK_ON && p.pixel_x < MAX_WIDTH_DEF
                    && p.pixel_y < MAX_HEIGHT_DEF) begin
                sx = longint'(col_sum) + p.pixel_x;
                sy = longint'(row_sum) + p.pixel_y;
                col_sum = (sx > (2**SUM_W - 1)) ? '1 : sx[SUM_W-1:0];
                row_sum = (sy > (2**SUM_W - 1)) ? '1 : sy[SUM_W-1:0];
                if (hits != AREA_ALL) hits = hits + 1'b1;
            end
            if (!p.frame_end) return;

            n = hits;
            if (n > 0) begin
                track_x = follow_centroid(track_x, col_sum, n);
                track_y = follow_centroid(track_y, row_sum, n);
            end
            area   = ref_area;
            lim_hi = area + area / GROW_DIVISOR_DEF;
            lim_lo = area + area / (2 * GROW_DIVISOR_DEF);
            if (n > lim_hi) active = 1'b1;
            else if (n < lim_lo) active = 1'b0;

            r.center_x      = track_x;
            r.center_y      = track_y;
            r.object_active = active;
            r.object_pixels = hits;
            r.object_found  = (n > 0);
            expected_frames.push_back(r);
            frames++;
            if (n == 0) empty_frames++;
            if (active) active_frames++;
            col_sum = '0;
            row_sum = '0;
            hits    = '0;
        endfunction

        function void compare_field(string name, int unsigned want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (expected_frames.size() == 0) begin
                $error("result with no frame pending: center (%0d,%0d) pixels %0d",
                       got.center_x, got.center_y, got.object_pixels);
                errors++;
                return;
            end
            want = expected_frames.pop_front();
            checked++;
            compare_field("center_x", want.center_x, got.center_x);
            compare_field("center_y", want.center_y, got.center_y);
            compare_field("object_active", want.object_active, got.object_active);
            compare_field("object_pixels", want.object_pixels, got.object_pixels);
            compare_field("object_found", want.object_found, got.object_found);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   idle_on;
    bit   stall_on;
    bit   hold_pending;
    int   pixels_sent;
    int   cfg_writes;
    int   cycle_count;
    centroid_scoreboard sb;

    mct_stream_if #(.T(t_pix)) pix_if ();
    mct_stream_if #(.T(t_res)) res_if ();
    mct_stream_if #(.T(t_cfg)) cfg_if ();

    mask_centroid_tracker_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_pix make_pix(int x, int y, int m, bit last);
        t_pix p;
        p.pixel_x    = x[COORD_W-1:0];
        p.pixel_y    = y[COORD_W-1:0];
        p.mask_value = m[MASK_W-1:0];
        p.frame_end  = last;
        return p;
    endfunction

    function automatic int clamp_coord(int v);
        if (v < 0) return 0;
        if (v > COORD_MAX) return COORD_MAX;
        return v;
    endfunction

    task automatic send_pixel(input t_pix p);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 10);
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.data  <= p;
        do @(posedge i_clk); while (!pix_if.ready);
        sb.note_pixel(p);
        pixels_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [AREA_W-1:0] value);
        t_cfg w;
        w.idx   = idx;
        w.wdata = value;
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= w;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.load_reg(idx, value);
        cfg_writes++;
    endtask

    // Every call also writes one index past the register file, which must be ignored.
    task automatic configure(input logic [MARGIN_W-1:0] m, input logic [AREA_W-1:0] a,
                             input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                             input bit load_start);
        write_reg(CFG_MARGIN, AREA_W'(m));
        write_reg(CFG_AREA, a);
        if (load_start) begin
            write_reg(CFG_START_X, AREA_W'(sx));
            write_reg(CFG_START_Y, AREA_W'(sy));
        end
        write_reg(CFG_IDX_W'($urandom_range(CFG_NUM_REGS, 2**CFG_IDX_W - 1)),
                  AREA_W'($urandom));
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        pix_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One frame: a cluster of object pixels mixed with non-object bytes. Half the
    // clusters sit near the tracked center so the centroid lands around the deadband edge.
    task automatic send_frame();
        int len;
        int hit_pct;
        int spread;
        int cx;
        int cy;
        int dx;
        int dy;
        int sel;
        int i;
        int m;
        sel = $urandom_range(0, 19);
        if (sel < 12) len = $urandom_range(1, 12);
        else if (sel < 18) len = $urandom_range(13, 60);
        else len = $urandom_range(61, 150);
        hit_pct = $urandom_range(0, 3) == 0 ? $urandom_range(0, 100) : $urandom_range(60, 100);
        spread  = $urandom_range(0, 3) == 0 ? $urandom_range(0, 511) : $urandom_range(0, 16);
        if ($urandom_range(0, 1) == 1) begin
            m  = sb.margin;
            dx = $urandom_range(0, 2 * m + 4);
            dy = $urandom_range(0, 2 * m + 4);
            cx = clamp_coord(int'(sb.track_x) + dx - m - 2);
            cy = clamp_coord(int'(sb.track_y) + dy - m - 2);
        end else begin
            cx = $urandom_range(0, COORD_MAX);
            cy = $urandom_range(0, COORD_MAX);
        end
        for (i = 0; i < len; i++) begin
            dx = $urandom_range(0, 2 * spread);
            dy = $urandom_range(0, 2 * spread);
            send_pixel(make_pix(clamp_coord(cx + dx - spread), clamp_coord(cy + dy - spread),
                                ($urandom_range(1, 100) <= hit_pct) ? MASK_ON
                                                                  : $urandom_range(0, 254),
                                i == len - 1));
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request so the block backs up.
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                res_if.ready <= 1'b1;
            end else if (stall_on && $urandom_range(0, 5) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            sb.check_result(res_if.data);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[mask_centroid_tracker_unit] ERROR");
        $finish;
    end

    initial begin
        int ph;
        int target;
        logic [MARGIN_W-1:0] m;
        logic [AREA_W-1:0]   a;

        sb = new();
        i_rst_n      = 1'b0;
        pix_if.valid = 1'b0;
        pix_if.data  = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        idle_on      = 1'b1;
        stall_on     = 1'b1;
        hold_pending = 1'b0;
        pixels_sent  = 0;
        cfg_writes   = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: margin of five, zero area, center at the origin.
        send_pixel(make_pix(COORD_MAX, COORD_MAX, 0, 1'b1));
        send_pixel(make_pix(5, 5, MASK_ON, 1'b1));
        send_pixel(make_pix(6, COORD_MAX, MASK_ON, 1'b1));
        send_pixel(make_pix(COORD_MAX, 0, MASK_ON, 1'b0));
        send_pixel(make_pix(0, COORD_MAX, MASK_ON - 1, 1'b0));
        send_pixel(make_pix(512, 512, 127, 1'b0));
        send_pixel(make_pix(COORD_MAX, 0, MASK_ON, 1'b1));

        // Zero deadband; the start center written must show up on an empty frame.
        wait_idle();
        configure(8'd0, AREA_ALL, COORD_MAX, 10'd0, 1'b1);
        send_pixel(make_pix(0, 0, 0, 1'b1));
        send_pixel(make_pix(COORD_MAX - 1, 1, MASK_ON, 1'b1));

        // Widest deadband: exactly on its edge the center holds, one past it moves.
        wait_idle();
        configure(8'd255, 21'd1, 10'd0, 10'd0, 1'b0);
        send_pixel(make_pix(0, COORD_MAX, MASK_ON, 1'b1));
        send_pixel(make_pix(255, 768, MASK_ON, 1'b1));
        send_pixel(make_pix(256, 767, MASK_ON, 1'b1));

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            m = ($urandom_range(0, 3) == 0) ? MARGIN_W'($urandom_range(0, 255))
                                            : MARGIN_W'($urandom_range(0, 12));
            a = AREA_W'($urandom_range(0, 60));
            case (ph)
                0: configure(8'd0, 21'd0, 10'd0, 10'd0, 1'b1);
                1: configure(8'd255, AREA_ALL, COORD_MAX, COORD_MAX, 1'b1);
                2: configure(m, AREA_TOP, COORD_W'($urandom_range(0, COORD_MAX)),
                             COORD_W'($urandom_range(0, COORD_MAX)), 1'b1);
                default: configure(m, a, COORD_W'($urandom_range(0, COORD_MAX)),
                                   COORD_W'($urandom_range(0, COORD_MAX)),
                                   1'($urandom_range(0, 1)));
            endcase
            if (ph == HOLD_PHASE) hold_pending = 1'b1;
            idle_on  = (ph != NUM_PHASES - 1);
            stall_on = (ph != NUM_PHASES - 1);
            target = pixels_sent + PHASE_PIXELS;
            while (pixels_sent < target) send_frame();
        end
        wait_idle();

        $display("Sent %0d pixels over %0d frames (%0d empty, %0d with the object active).",
                 pixels_sent, sb.frames, sb.empty_frames, sb.active_frames);
        $display("Checked %0d results across %0d register writes.", sb.checked, cfg_writes);
        if (sb.errors == 0) begin
            $display("[mask_centroid_tracker_unit] OK");
        end else begin
            $display("[mask_centroid_tracker_unit] ERROR");
        end
        $finish;
    end

endmodule

>>> mask_centroid_tracker_unit.f
hdl/mct_pkg.sv
hdl/mct_stream_if.sv
hdl/mct_ctrl.sv
hdl/mct_datapath.sv
hdl/mask_centroid_tracker_unit.sv
tb/sv/tb_mask_centroid_tracker_unit.sv
